// ----- design/assert_macros.svh -----
// Assertion macros used by the parser core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/arfp_pkg.sv -----
// Types and constants for the AT response frame parser
package arfp_pkg;

    localparam int MAX_FRAME_LEN = 128;

    localparam logic [7:0] MAX_LEN     = 8'(MAX_FRAME_LEN);
    localparam logic [7:0] TYPE_LOCAL  = 8'h88;
    localparam logic [7:0] TYPE_REMOTE = 8'h97;
    localparam logic [7:0] HDR_LOCAL   = 8'd5;
    localparam logic [7:0] HDR_REMOTE  = 8'd15;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_SUM  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TYPE  = 2'd1,
        ERR_SHORT = 2'd2,
        ERR_LONG  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0]  frame_id;
        logic [15:0] at_command;
        logic [7:0]  cmd_status;
        logic [63:0] addr64;
        logic [15:0] addr16;
    } t_held;

    typedef struct packed {
        logic       has_data;
        logic       has_sum;
        logic [7:0] data_byte;
        t_held      held;
        logic       has_address;
        t_err       err;
        logic [7:0] count;
    } t_entry;

    typedef struct packed {
        logic [Q_AW:0] count;
        logic          full;
        logic          empty;
    } t_q_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        t_held      held;
        logic       has_address;
        t_err       err;
        logic [7:0] count;
        logic       last;
    } t_result;

endpackage

// ----- design/arfp_front.sv -----
// Front end: byte position tracking, header capture and classification
module arfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_frame,
    output logic              o_push,
    output arfp_pkg::t_entry  o_entry
);

    logic [7:0]      r_pos, n_pos;
    logic            r_remote, n_remote;
    logic            r_bad, n_bad;
    arfp_pkg::t_held r_held, n_held;

    logic            w_first;
    logic            w_capture;
    logic            w_data;
    logic [7:0]      w_hdr;
    logic [8:0]      w_len;
    arfp_pkg::t_held w_base;

    always_comb begin
        w_first  = (r_pos == 8'd0);
        n_remote = w_first ? (i_in_byte == arfp_pkg::TYPE_REMOTE) : r_remote;
        n_bad    = w_first ? ((i_in_byte != arfp_pkg::TYPE_LOCAL) &&
                              (i_in_byte != arfp_pkg::TYPE_REMOTE)) : r_bad;
        w_hdr     = n_remote ? arfp_pkg::HDR_REMOTE : arfp_pkg::HDR_LOCAL;
        w_capture = !w_first && !n_bad;
        w_base    = w_first ? '0 : r_held;
        n_held    = w_base;

        if (w_capture && r_pos == 8'd1)
            n_held.frame_id = i_in_byte;
        if (w_capture && n_remote && r_pos >= 8'd2 && r_pos <= 8'd9)
            n_held.addr64 = {w_base.addr64[55:0], i_in_byte};
        if (w_capture && n_remote && (r_pos == 8'd10 || r_pos == 8'd11))
            n_held.addr16 = {w_base.addr16[7:0], i_in_byte};
        if (w_capture && (r_pos == w_hdr - 8'd3 || r_pos == w_hdr - 8'd2))
            n_held.at_command = {w_base.at_command[7:0], i_in_byte};
        if (w_capture && r_pos == w_hdr - 8'd1)
            n_held.cmd_status = i_in_byte;

        w_data = w_capture && (r_pos >= w_hdr) && (r_pos < arfp_pkg::MAX_LEN);
        w_len  = {1'b0, r_pos} + 9'd1;

        o_entry.has_data    = w_data;
        o_entry.has_sum     = i_end_of_frame;
        o_entry.data_byte   = i_in_byte;
        o_entry.held        = n_held;
        o_entry.has_address = n_remote && !n_bad;
        priority if (n_bad) begin
            o_entry.err   = arfp_pkg::ERR_TYPE;
            o_entry.count = 8'd0;
        end else if (w_len < {1'b0, w_hdr}) begin
            o_entry.err   = arfp_pkg::ERR_SHORT;
            o_entry.count = 8'd0;
        end else if (w_len > {1'b0, arfp_pkg::MAX_LEN}) begin
            o_entry.err   = arfp_pkg::ERR_LONG;
            o_entry.count = arfp_pkg::MAX_LEN - w_hdr;
        end else begin
            o_entry.err   = arfp_pkg::ERR_NONE;
            o_entry.count = w_len[7:0] - w_hdr;
        end

        o_push = i_accept && (w_data || i_end_of_frame);

        if (i_end_of_frame)
            n_pos = 8'd0;
        else if (r_pos != 8'hFF)
            n_pos = r_pos + 8'd1;
        else
            n_pos = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_remote <= 1'b0;
            r_bad    <= 1'b0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_remote <= n_remote;
            r_bad    <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept)
            r_held <= n_held;
    end

endmodule

// ----- design/arfp_queue.sv -----
// Short register queue between the front and back ends
module arfp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  arfp_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output arfp_pkg::t_entry     o_head,
    output arfp_pkg::t_q_status  o_status
);

    arfp_pkg::t_entry                r_mem [arfp_pkg::Q_DEPTH];
    logic [arfp_pkg::Q_AW-1:0]       r_wr, r_rd;
    logic [arfp_pkg::Q_AW:0]         r_count;

    always_comb begin
        o_head          = r_mem[r_rd];
        o_status.count  = r_count;
        o_status.full   = (r_count == (arfp_pkg::Q_AW+1)'(arfp_pkg::Q_DEPTH));
        o_status.empty  = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (i_pop)
                r_rd <= r_rd + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_entry;
    end

endmodule

// ----- design/arfp_back.sv -----
// Back end: splits queue entries into data and summary results
module arfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arfp_pkg::t_entry  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output arfp_pkg::t_result o_result
);

    logic                r_out_valid, n_out_valid;
    logic                r_sum_pend, n_sum_pend;
    arfp_pkg::t_result   r_out, n_out;
    arfp_pkg::t_result   w_data_res, w_sum_res;
    logic                w_load;

    always_comb begin
        w_data_res           = '0;
        w_data_res.kind      = arfp_pkg::KIND_DATA;
        w_data_res.data_byte = i_head.data_byte;
        w_data_res.err       = arfp_pkg::ERR_NONE;

        w_sum_res             = '0;
        w_sum_res.kind        = arfp_pkg::KIND_SUM;
        w_sum_res.held        = i_head.held;
        w_sum_res.has_address = i_head.has_address;
        w_sum_res.err         = i_head.err;
        w_sum_res.count       = i_head.count;
        w_sum_res.last        = 1'b1;

        n_out_valid = r_out_valid;
        n_sum_pend  = r_sum_pend;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_load      = !r_out_valid || !i_stall;

        if (w_load) begin
            n_out_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.has_data && !r_sum_pend) begin
                    n_out = w_data_res;
                    if (i_head.has_sum)
                        n_sum_pend = 1'b1;
                    else
                        o_pop = 1'b1;
                end else begin
                    n_out      = w_sum_res;
                    n_sum_pend = 1'b0;
                    o_pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum_pend  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sum_pend  <= n_sum_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- design/at_response_frame_parser_core.sv -----
// Top level of the AT response frame parser
// Path: an accepted byte is written into the queue, and a result is loaded into the
// output register when that register is empty or not stalled, which sets o_valid.
// Throughput: one byte per cycle while the queue is not full (o_stall); a final byte
// that is also data yields a data result and then a summary, held in the four-entry queue.
// Reset: synchronous, active low; clears byte position, queue and output valid.
`include "assert_macros.svh"
module at_response_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_frame,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_frame_id,
    output logic [15:0] o_at_command,
    output logic [7:0]  o_cmd_status,
    output logic [63:0] o_source_addr64,
    output logic [15:0] o_source_addr16,
    output logic        o_has_address,
    output logic [1:0]  o_error_code,
    output logic [7:0]  o_data_count,
    output logic        o_last
);

    logic                w_accept;
    logic                w_push;
    logic                w_pop;
    arfp_pkg::t_entry    w_entry;
    arfp_pkg::t_entry    w_head;
    arfp_pkg::t_q_status w_qs;
    arfp_pkg::t_result   w_res;

    assign o_stall  = w_qs.full;
    assign w_accept = i_valid && !o_stall;

    arfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    arfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qs)
    );

    arfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_qs.empty),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_res)
    );

    assign o_result_kind   = w_res.kind;
    assign o_data_byte     = w_res.data_byte;
    assign o_frame_id      = w_res.held.frame_id;
    assign o_at_command    = w_res.held.at_command;
    assign o_cmd_status    = w_res.held.cmd_status;
    assign o_source_addr64 = w_res.held.addr64;
    assign o_source_addr16 = w_res.held.addr16;
    assign o_has_address   = w_res.has_address;
    assign o_error_code    = w_res.err;
    assign o_data_count    = w_res.count;
    assign o_last          = w_res.last;

    `ASSERT_IMPL(a_q_bound, 1'b1, w_qs.count <= (arfp_pkg::Q_AW+1)'(arfp_pkg::Q_DEPTH), "queue overflow")
    `ASSERT_IMPL(a_no_pop_empty, w_pop, !w_qs.empty, "pop from empty queue")
    `ASSERT_IMPL(a_data_clean, o_valid && !o_result_kind, !o_last && o_data_count == 8'd0 && o_error_code == arfp_pkg::ERR_NONE, "data result carries summary")
    `ASSERT_IMPL(a_bad_type, o_valid && o_result_kind && o_error_code == arfp_pkg::ERR_TYPE, !o_has_address && o_data_count == 8'd0 && o_frame_id == 8'd0, "bad type summary not empty")

endmodule

// ----- bench/at_response_frame_parser_core_tb.sv -----
// Self-checking testbench for the AT response frame parser core
`timescale 1ns / 1ps

module at_response_frame_parser_core_tb;

    localparam int SIDE_IN        = 0;
    localparam int SIDE_OUT       = 1;
    localparam int FILL_RANDOM    = 0;
    localparam int FILL_ZERO      = 1;
    localparam int FILL_ONES      = 2;
    localparam int RANDOM_BYTES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_eof    = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_kind;
    logic [7:0]  out_data_byte;
    logic [7:0]  out_frame_id;
    logic [15:0] out_at_command;
    logic [7:0]  out_cmd_status;
    logic [63:0] out_addr64;
    logic [15:0] out_addr16;
    logic        out_has_address;
    logic [1:0]  out_error_code;
    logic [7:0]  out_data_count;
    logic        out_last;

    // parser state mirrored by the testbench
    logic [7:0]        byte_pos     = 8'd0;
    logic              remote_frame = 1'b0;
    logic              unknown_type = 1'b0;
    arfp_pkg::t_held   held         = '0;

    arfp_pkg::t_result pending_results[$];
    logic [7:0]        frame_bytes[$];
    logic              frame_ends[$];
    int                calm_left[2];
    int                stall_left   = 0;
    int                idle_cycles  = 0;
    int                error_count  = 0;
    int                bytes_sent   = 0;

    at_response_frame_parser_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_in_byte       (in_byte),
        .i_end_of_frame  (in_eof),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_result_kind   (out_kind),
        .o_data_byte     (out_data_byte),
        .o_frame_id      (out_frame_id),
        .o_at_command    (out_at_command),
        .o_cmd_status    (out_cmd_status),
        .o_source_addr64 (out_addr64),
        .o_source_addr16 (out_addr16),
        .o_has_address   (out_has_address),
        .o_error_code    (out_error_code),
        .o_data_count    (out_data_count),
        .o_last          (out_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(15) == 0) begin
            calm_left[side] = int'($urandom_range(40, 15));
            return 0;
        end
        return int'($urandom_range(7));
    endfunction

    // expected results of one byte, pushed in output order
    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        int                hdr;
        int                len;
        arfp_pkg::t_result r;
        if (byte_pos == 0) begin
            held         = '0;
            remote_frame = (b == arfp_pkg::TYPE_REMOTE);
            unknown_type = (b != arfp_pkg::TYPE_LOCAL) && (b != arfp_pkg::TYPE_REMOTE);
        end
        hdr = remote_frame ? int'(arfp_pkg::HDR_REMOTE) : int'(arfp_pkg::HDR_LOCAL);
        if (byte_pos != 0 && !unknown_type) begin
            if (byte_pos == 1)
                held.frame_id = b;
            if (remote_frame && byte_pos >= 2 && byte_pos <= 9)
                held.addr64 = {held.addr64[55:0], b};
            if (remote_frame && (byte_pos == 10 || byte_pos == 11))
                held.addr16 = {held.addr16[7:0], b};
            if (byte_pos == hdr - 3 || byte_pos == hdr - 2)
                held.at_command = {held.at_command[7:0], b};
            if (byte_pos == hdr - 1)
                held.cmd_status = b;
            if (byte_pos >= hdr && byte_pos < arfp_pkg::MAX_FRAME_LEN) begin
                r           = '0;
                r.kind      = arfp_pkg::KIND_DATA;
                r.data_byte = b;
                pending_results.push_back(r);
            end
        end
        if (eof) begin
            len           = int'(byte_pos) + 1;
            r             = '0;
            r.kind        = arfp_pkg::KIND_SUM;
            r.held        = held;
            r.has_address = remote_frame && !unknown_type;
            r.last        = 1'b1;
            if (unknown_type) begin
                r.err = arfp_pkg::ERR_TYPE;
            end else if (len < hdr) begin
                r.err = arfp_pkg::ERR_SHORT;
            end else if (len > arfp_pkg::MAX_FRAME_LEN) begin
                r.err   = arfp_pkg::ERR_LONG;
                r.count = 8'(arfp_pkg::MAX_FRAME_LEN - hdr);
            end else begin
                r.err   = arfp_pkg::ERR_NONE;
                r.count = 8'(len - hdr);
            end
            pending_results.push_back(r);
            byte_pos = 8'd0;
        end else if (byte_pos != 8'hFF) begin
            byte_pos++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_result();
        arfp_pkg::t_result e;
        if (pending_results.size() == 0) begin
            $error("result_kind: expected none, got %0h (data_byte %0h)",
                   out_kind, out_data_byte);
            error_count++;
        end else begin
            e = pending_results.pop_front();
            check_field("result_kind", e.kind, out_kind);
            check_field("data_byte", e.data_byte, out_data_byte);
            check_field("frame_id", e.held.frame_id, out_frame_id);
            check_field("at_command", e.held.at_command, out_at_command);
            check_field("cmd_status", e.held.cmd_status, out_cmd_status);
            check_field("source_addr64", e.held.addr64, out_addr64);
            check_field("source_addr16", e.held.addr16, out_addr16);
            check_field("has_address", e.has_address, out_has_address);
            check_field("error_code", e.err, out_error_code);
            check_field("data_count", e.count, out_data_count);
            check_field("last", e.last, out_last);
        end
    endtask

    // result checking, receiver stalls and watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall   <= 1'b0;
            stall_left  = 0;
            idle_cycles = 0;
        end else begin
            if (out_valid && !out_stall) begin
                check_result();
                stall_left = draw_wait(SIDE_OUT);
                out_stall <= (stall_left != 0);
            end else if (stall_left != 0) begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = draw_wait(SIDE_IN);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        parse_byte(b, eof);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eof   <= eof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    function automatic void make_frame(input logic [7:0] ftype, input int len,
                                       input int fill);
        logic [7:0] b;
        frame_bytes.delete();
        frame_ends.delete();
        frame_bytes.push_back(ftype);
        frame_ends.push_back(len == 1);
        for (int k = 1; k < len; k++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            frame_bytes.push_back(b);
            frame_ends.push_back(k == len - 1);
        end
    endfunction

    task automatic send_frame();
        for (int k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], frame_ends[k]);
    endtask

    task automatic test_local_frames();
        make_frame(arfp_pkg::TYPE_LOCAL, 5, FILL_ZERO);
        send_frame();
        make_frame(arfp_pkg::TYPE_LOCAL, 6, FILL_ONES);
        send_frame();
    endtask

    task automatic test_remote_frames();
        make_frame(arfp_pkg::TYPE_REMOTE, 15, FILL_ONES);
        send_frame();
    endtask

    task automatic test_unknown_type();
        make_frame(8'h00, 1, FILL_ZERO);
        send_frame();
        make_frame(8'hFF, 2, FILL_ONES);
        send_frame();
    endtask

    task automatic test_short_frames();
        make_frame(arfp_pkg::TYPE_LOCAL, 1, FILL_RANDOM);
        send_frame();
        make_frame(arfp_pkg::TYPE_REMOTE, 1, FILL_RANDOM);
        send_frame();
    endtask

    // longest legal frame, and an over-long frame past position saturation
    task automatic test_length_limit();
        make_frame(arfp_pkg::TYPE_LOCAL, arfp_pkg::MAX_FRAME_LEN, FILL_RANDOM);
        send_frame();
        make_frame(arfp_pkg::TYPE_REMOTE, 260, FILL_RANDOM);
        send_frame();
    endtask

    task automatic test_random_frames();
        int         first;
        int         pick;
        int         hdr;
        logic [7:0] ftype;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            pick  = int'($urandom_range(99));
            ftype = $urandom_range(1) ? arfp_pkg::TYPE_REMOTE : arfp_pkg::TYPE_LOCAL;
            hdr   = (ftype == arfp_pkg::TYPE_REMOTE) ? int'(arfp_pkg::HDR_REMOTE)
                                                     : int'(arfp_pkg::HDR_LOCAL);
            if (pick < 60) begin
                make_frame(ftype, hdr + int'($urandom_range(12)), FILL_RANDOM);
            end else if (pick < 70) begin
                make_frame(ftype, int'($urandom_range(hdr - 1, 1)), FILL_RANDOM);
            end else if (pick < 80) begin
                do ftype = 8'($urandom);
                while (ftype == arfp_pkg::TYPE_LOCAL || ftype == arfp_pkg::TYPE_REMOTE);
                make_frame(ftype, int'($urandom_range(8, 1)), FILL_RANDOM);
            end else if (pick < 82) begin
                make_frame(ftype, int'($urandom_range(arfp_pkg::MAX_FRAME_LEN + 2,
                                                      arfp_pkg::MAX_FRAME_LEN - 2)),
                           FILL_RANDOM);
            end else begin
                make_frame(8'($urandom), int'($urandom_range(20, 1)), FILL_RANDOM);
                for (int k = 0; k < frame_ends.size() - 1; k++)
                    frame_ends[k] = ($urandom_range(3) == 0);
            end
            send_frame();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_local_frames();
        test_remote_frames();
        test_unknown_type();
        test_short_frames();
        test_length_limit();
        test_random_frames();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
